/* hw/rtl/dfsft_pkg.sv */
// Shared types and constants for the depth-first search timestamp block.
// No dependencies; used by the core, the testbench checker and the testbench top.
package dfsft_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int EntrySlots  = 2 * MaxEdges;
  localparam int VW          = $clog2(MaxVertices);
  localparam int EW          = $clog2(EntrySlots);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [6:0] ROOT_CODE   = 7'h7f;
  localparam logic [6:0] VCOUNT_RST  = 7'd64;
  localparam logic       REG_VCOUNT  = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_RB, ST_ADD_WB, ST_ADD_RA, ST_ADD_WA,
    ST_ROOT, ST_HEAD_WAIT, ST_WALK, ST_EDGE_WAIT, ST_POP_WAIT,
    ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_OUT
  } state_t;
endpackage

/* hw/rtl/dfsft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfsft_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/dfs_discovery_finish_times_core.sv */
// Depth-first search with discovery/finish stamps; depends on dfsft_pkg, dfsft_ram.
// Add edge: read and write the head of b, then of a; clear acts while idle; run: a search
// through the head, edge and stack stores, then each result is read, loaded and held until taken.
// One transaction at a time; s_tready is high only when the sequencer is idle.
// Reset (rst, synchronous): graph empty, vertex_count 64, no result pending.
module dfs_discovery_finish_times_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd[1:0], vertex_a[7:2], vertex_b[13:8], zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // vertex_id[5:0], parent_vertex[12:6],
                                 // discovery_time[20:13], finish_time[28:21], zeros
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int VW = dfsft_pkg::VW;
  localparam int EW = dfsft_pkg::EW;

  dfsft_pkg::state_t state, state_next;

  logic [6:0]    vcount, n_act;
  logic [EW:0]   eu;
  logic [dfsft_pkg::MaxVertices-1:0] hvld, vis;
  logic [7:0]    tmr;
  logic [6:0]    root;
  logic [VW-1:0] cur_u, sp, emit_i, va, vb;
  logic [EW-1:0] cur_link;
  logic          link_nul;

  logic [1:0]    in_cmd;
  logic [VW-1:0] in_a, in_b;
  logic          add_ok, push_ok;
  logic [VW-1:0] w;

  logic          head_we, edge_we, stk_we, pd_we, fin_we;
  logic [VW-1:0] head_waddr, head_raddr, stk_waddr, stk_raddr, pd_waddr, fin_waddr;
  logic [EW-1:0] head_wdata, head_rdata, edge_waddr, edge_raddr;
  logic [15:0]   edge_wdata, edge_rdata, stk_wdata, stk_rdata;
  logic [14:0]   pd_wdata, pd_rdata;
  logic [7:0]    fin_wdata, fin_rdata;

  assign in_cmd = s_tdata[1:0];
  assign in_a   = s_tdata[7:2];
  assign in_b   = s_tdata[13:8];
  assign n_act  = (vcount > 7'(dfsft_pkg::MaxVertices)) ? 7'(dfsft_pkg::MaxVertices) : vcount;
  assign add_ok = ({1'b0, in_a} < n_act) && ({1'b0, in_b} < n_act)
                  && (eu <= (EW+1)'(dfsft_pkg::EntrySlots - 2));
  assign w       = edge_rdata[VW-1:0];
  assign push_ok = ({1'b0, w} < n_act) && !vis[w] && (sp != {VW{1'b1}});

  assign s_tready = (state == dfsft_pkg::ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = {25'd0, vcount};

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= dfsft_pkg::VCOUNT_RST;
    end else if (psel && penable && pwrite && paddr == dfsft_pkg::REG_VCOUNT) begin
      vcount <= pwdata[6:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dfsft_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_cmd == dfsft_pkg::CMD_ADD && add_ok) state_next = dfsft_pkg::ST_ADD_RB;
          else if (in_cmd == dfsft_pkg::CMD_RUN)      state_next = dfsft_pkg::ST_ROOT;
        end
      end
      dfsft_pkg::ST_ADD_RB: state_next = dfsft_pkg::ST_ADD_WB;
      dfsft_pkg::ST_ADD_WB: state_next = dfsft_pkg::ST_ADD_RA;
      dfsft_pkg::ST_ADD_RA: state_next = dfsft_pkg::ST_ADD_WA;
      dfsft_pkg::ST_ADD_WA: state_next = dfsft_pkg::ST_IDLE;
      dfsft_pkg::ST_ROOT: begin
        if (root >= n_act)
          state_next = (n_act == 7'd0) ? dfsft_pkg::ST_IDLE : dfsft_pkg::ST_EMIT_RD;
        else if (!vis[root[VW-1:0]]) state_next = dfsft_pkg::ST_HEAD_WAIT;
      end
      dfsft_pkg::ST_HEAD_WAIT: state_next = dfsft_pkg::ST_WALK;
      dfsft_pkg::ST_WALK: begin
        if (!link_nul)     state_next = dfsft_pkg::ST_EDGE_WAIT;
        else if (sp == '0) state_next = dfsft_pkg::ST_ROOT;
        else               state_next = dfsft_pkg::ST_POP_WAIT;
      end
      dfsft_pkg::ST_EDGE_WAIT:
        state_next = push_ok ? dfsft_pkg::ST_HEAD_WAIT : dfsft_pkg::ST_WALK;
      dfsft_pkg::ST_POP_WAIT: state_next = dfsft_pkg::ST_WALK;
      dfsft_pkg::ST_EMIT_RD:  state_next = dfsft_pkg::ST_EMIT_LD;
      dfsft_pkg::ST_EMIT_LD:  state_next = dfsft_pkg::ST_EMIT_OUT;
      dfsft_pkg::ST_EMIT_OUT: begin
        if (m_tready)
          state_next = ({1'b0, emit_i} + 7'd1 == n_act) ? dfsft_pkg::ST_IDLE
                                                        : dfsft_pkg::ST_EMIT_RD;
      end
      default: state_next = dfsft_pkg::ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    head_we    = 1'b0;
    head_waddr = (state == dfsft_pkg::ST_ADD_WB) ? vb : va;
    head_wdata = eu[EW-1:0];
    head_raddr = cur_u;
    edge_we    = 1'b0;
    edge_waddr = eu[EW-1:0];
    edge_wdata = (state == dfsft_pkg::ST_ADD_WB) ? {!hvld[vb], head_rdata, va}
                                                 : {!hvld[va], head_rdata, vb};
    edge_raddr = cur_link;
    stk_we     = 1'b0;
    stk_waddr  = sp;
    stk_wdata  = {edge_rdata[15:VW], cur_u};
    stk_raddr  = sp - VW'(1);
    pd_we      = 1'b0;
    pd_waddr   = w;
    pd_wdata   = {1'b0, cur_u, tmr + 8'd1};
    fin_we     = 1'b0;
    fin_waddr  = cur_u;
    fin_wdata  = tmr + 8'd1;
    case (state)
      dfsft_pkg::ST_ADD_RB: head_raddr = vb;
      dfsft_pkg::ST_ADD_RA: head_raddr = va;
      dfsft_pkg::ST_ADD_WB, dfsft_pkg::ST_ADD_WA: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      dfsft_pkg::ST_ROOT: begin
        head_raddr = root[VW-1:0];
        pd_waddr   = root[VW-1:0];
        pd_wdata   = {dfsft_pkg::ROOT_CODE, tmr + 8'd1};
        pd_we      = (root < n_act) && !vis[root[VW-1:0]];
      end
      dfsft_pkg::ST_WALK: fin_we = link_nul;
      dfsft_pkg::ST_EDGE_WAIT: begin
        head_raddr = w;
        stk_we     = push_ok;
        pd_we      = push_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dfsft_pkg::ST_IDLE;
      eu       <= '0;
      hvld     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        dfsft_pkg::ST_IDLE: begin
          va <= in_a;
          vb <= in_b;
          if (s_tvalid && in_cmd == dfsft_pkg::CMD_CLEAR) begin
            hvld <= '0;
            eu   <= '0;
          end
          if (s_tvalid && in_cmd == dfsft_pkg::CMD_RUN) begin
            vis    <= '0;
            tmr    <= '0;
            root   <= '0;
            emit_i <= '0;
          end
        end
        dfsft_pkg::ST_ADD_WB: begin
          hvld[vb] <= 1'b1;
          eu       <= eu + (EW+1)'(1);
        end
        dfsft_pkg::ST_ADD_WA: begin
          hvld[va] <= 1'b1;
          eu       <= eu + (EW+1)'(1);
        end
        dfsft_pkg::ST_ROOT: begin
          if (root < n_act) begin
            if (vis[root[VW-1:0]]) begin
              root <= root + 7'd1;
            end else begin
              vis[root[VW-1:0]] <= 1'b1;
              tmr   <= tmr + 8'd1;
              cur_u <= root[VW-1:0];
              sp    <= '0;
            end
          end
        end
        dfsft_pkg::ST_HEAD_WAIT: begin
          cur_link <= head_rdata;
          link_nul <= !hvld[cur_u];
        end
        dfsft_pkg::ST_WALK: begin
          if (link_nul) begin
            tmr <= tmr + 8'd1;
            if (sp == '0) root <= root + 7'd1;
            else          sp   <= sp - VW'(1);
          end
        end
        dfsft_pkg::ST_EDGE_WAIT: begin
          cur_link <= edge_rdata[VW+EW-1:VW];
          link_nul <= edge_rdata[15];
          if (push_ok) begin
            vis[w] <= 1'b1;
            tmr    <= tmr + 8'd1;
            cur_u  <= w;
            sp     <= sp + VW'(1);
          end
        end
        dfsft_pkg::ST_POP_WAIT: begin
          cur_u    <= stk_rdata[VW-1:0];
          cur_link <= stk_rdata[VW+EW-1:VW];
          link_nul <= stk_rdata[15];
        end
        dfsft_pkg::ST_EMIT_LD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {3'd0, fin_rdata, pd_rdata[7:0], pd_rdata[14:8], emit_i};
          m_tlast  <= ({1'b0, emit_i} + 7'd1 == n_act);
        end
        dfsft_pkg::ST_EMIT_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            emit_i   <= emit_i + VW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  dfsft_ram #(.W(EW), .D(dfsft_pkg::MaxVertices)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  dfsft_ram #(.W(16), .D(dfsft_pkg::EntrySlots)) u_edge (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata));
  dfsft_ram #(.W(16), .D(dfsft_pkg::MaxVertices)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  dfsft_ram #(.W(15), .D(dfsft_pkg::MaxVertices)) u_pd (
    .clk, .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
    .raddr(emit_i), .rdata(pd_rdata));
  dfsft_ram #(.W(8), .D(dfsft_pkg::MaxVertices)) u_fin (
    .clk, .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
    .raddr(emit_i), .rdata(fin_rdata));
endmodule

/* hw/rtl/dfsft_checker.sv */
// Port-level checks for the depth-first search timestamp core.
// Depends on dfs_discovery_finish_times_core; bound to it below.
module dfsft_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while results pending");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("back-to-back results from single-port fetch");
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:13] < m_tdata[28:21])
    else $error("finish time not after discovery");
endmodule

bind dfs_discovery_finish_times_core dfsft_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata);

/* verif/dfsft_checker.sv */
`timescale 1ns / 100ps
// Checker for the DFS timestamp core: watches input, output and register writes,
// predicts the per-vertex parent/discovery/finish results and compares them.
// Depends on dfsft_pkg for command codes and sizes.
module dfsft_tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  localparam logic [15:0] NoLink = 16'hffff;

  typedef struct packed {
    logic [5:0] vid;
    logic [6:0] parent;
    logic [7:0] disc;
    logic [7:0] fin;
    logic       last;
  } stamp_t;

  stamp_t     stamp_q[$];
  logic [6:0] vcount;
  logic [15:0] head [dfsft_pkg::MaxVertices];
  logic [5:0]  nbr_of [dfsft_pkg::EntrySlots];
  logic [15:0] next_of [dfsft_pkg::EntrySlots];
  int          used;

  assign pending = stamp_q.size();

  function automatic int active_n();
    return (vcount > dfsft_pkg::MaxVertices) ? dfsft_pkg::MaxVertices : int'(vcount);
  endfunction

  task automatic add_edge(int a, int b);
    int n;
    n = active_n();
    if (a < n && b < n && used + 2 <= dfsft_pkg::EntrySlots) begin
      nbr_of[used] = 6'(a); next_of[used] = head[b]; head[b] = 16'(used); used++;
      nbr_of[used] = 6'(b); next_of[used] = head[a]; head[a] = 16'(used); used++;
    end
  endtask

  task automatic predict_search();
    logic [1:0]  colour [dfsft_pkg::MaxVertices];
    logic [6:0]  par [dfsft_pkg::MaxVertices];
    logic [7:0]  dsc [dfsft_pkg::MaxVertices];
    logic [7:0]  fns [dfsft_pkg::MaxVertices];
    logic [5:0]  stk_v [dfsft_pkg::MaxVertices];
    logic [15:0] stk_l [dfsft_pkg::MaxVertices];
    logic [7:0]  clock_t;
    int n, sp, u, w;
    logic [15:0] e;
    stamp_t s;
    n = active_n();
    clock_t = 8'd0;
    for (int i = 0; i < dfsft_pkg::MaxVertices; i++) begin
      colour[i] = 2'd0; par[i] = dfsft_pkg::ROOT_CODE; dsc[i] = 8'd0; fns[i] = 8'd0;
    end
    for (int r = 0; r < n; r++) begin
      if (colour[r] != 2'd0) continue;
      clock_t++; dsc[r] = clock_t; colour[r] = 2'd1;
      stk_v[0] = 6'(r); stk_l[0] = head[r]; sp = 1;
      while (sp > 0) begin
        u = int'(stk_v[sp-1]);
        e = stk_l[sp-1];
        if (e == NoLink || e >= dfsft_pkg::EntrySlots) begin
          colour[u] = 2'd2; clock_t++; fns[u] = clock_t; sp--;
        end else begin
          w = int'(nbr_of[e]);
          stk_l[sp-1] = next_of[e];
          if (w < n && colour[w] == 2'd0 && sp < dfsft_pkg::MaxVertices) begin
            par[w] = 7'(u); clock_t++; dsc[w] = clock_t; colour[w] = 2'd1;
            stk_v[sp] = 6'(w); stk_l[sp] = head[w]; sp++;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      s.vid = 6'(i); s.parent = par[i]; s.disc = dsc[i]; s.fin = fns[i];
      s.last = (i + 1 == n);
      stamp_q.push_back(s);
    end
  endtask

  always @(posedge clk) begin
    stamp_t got, want;
    if (rst) begin
      vcount <= dfsft_pkg::VCOUNT_RST;
      used = 0;
      for (int i = 0; i < dfsft_pkg::MaxVertices; i++) head[i] = NoLink;
      stamp_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == dfsft_pkg::REG_VCOUNT)
        vcount <= pwdata[6:0];
      if (s_tvalid && s_tready) begin
        case (s_tdata[1:0])
          dfsft_pkg::CMD_ADD:   add_edge(int'(s_tdata[7:2]), int'(s_tdata[13:8]));
          dfsft_pkg::CMD_RUN:   predict_search();
          dfsft_pkg::CMD_CLEAR: begin
            for (int i = 0; i < dfsft_pkg::MaxVertices; i++) head[i] = NoLink;
            used = 0;
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[5:0], m_tdata[12:6], m_tdata[20:13], m_tdata[28:21], m_tlast};
        if (stamp_q.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = stamp_q.pop_front();
          if (got !== want) fail_count <= fail_count + 1;
          if (got.vid !== want.vid)
            $error("vertex_id exp %0d got %0d", want.vid, got.vid);
          if (got.parent !== want.parent)
            $error("parent_vertex exp %h got %h", want.parent, got.parent);
          if (got.disc !== want.disc)
            $error("discovery_time exp %0d got %0d", want.disc, got.disc);
          if (got.fin !== want.fin)
            $error("finish_time exp %0d got %0d", want.fin, got.fin);
          if (got.last !== want.last)
            $error("last_vertex exp %0d got %0d", want.last, got.last);
        end
      end
    end
  end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top of the DFS timestamp testbench: clock, reset, edge/run/clear stimulus,
// register writes and output stalls. Depends on dfsft_pkg, the core and dfsft_tb_checker.
module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [0:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          cycles = 0;
  int          hold_off = 0;
  int          rx_wait = 0;
  bit          hold_req = 0;
  bit          hold_taken = 0;

  localparam int CycleLimit = 1500000;

  always #2 clk = ~clk;

  dfs_discovery_finish_times_core dut (.*);
  dfsft_tb_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: a drawn wait per transaction, plus one long hold-off when requested.
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      m_tready <= 0;
      rx_wait  <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_off   <= 300;
      m_tready   <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (m_tvalid && m_tready) begin
      draw = $urandom_range(0, 9);
      rx_wait  <= draw;
      m_tready <= (draw == 0);
    end else if (!m_tready) begin
      if (rx_wait > 1) rx_wait <= rx_wait - 1;
      else begin
        rx_wait  <= 0;
        m_tready <= 1;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [5:0] a, logic [5:0] b);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    s_tvalid <= 1;
    s_tdata  <= {2'b00, b, a, cmd};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 0;
  endtask

  task automatic write_count(logic [6:0] v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= dfsft_pkg::REG_VCOUNT;
    pwdata <= {$urandom} & 32'hffff_ff80 | {25'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_graph(int n, int edges);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom));
      else
        send(dfsft_pkg::CMD_ADD, 6'($urandom_range(0, n - 1)),
             6'($urandom_range(0, n - 1)));
    end
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, self loop, out-of-range endpoint, unused command.
    send(dfsft_pkg::CMD_ADD, 6'd0, 6'd63);
    send(dfsft_pkg::CMD_ADD, 6'd63, 6'd63);
    send(dfsft_pkg::CMD_ADD, 6'd5, 6'd5);
    send(dfsft_pkg::CMD_ADD, 6'd0, 6'd5);
    send(2'd3, 6'h2a, 6'h15);
    send(dfsft_pkg::CMD_RUN, 6'h3f, 6'h3f);
    write_count(7'd4);
    send(dfsft_pkg::CMD_ADD, 6'd1, 6'd2);
    send(dfsft_pkg::CMD_ADD, 6'd4, 6'd1);
    send(dfsft_pkg::CMD_ADD, 6'd3, 6'd2);
    send(dfsft_pkg::CMD_ADD, 6'd2, 6'd0);
    send(dfsft_pkg::CMD_RUN, 6'd0, 6'd0);
    // Count lowered after loading: stored neighbour above count is skipped.
    write_count(7'd2);
    send(dfsft_pkg::CMD_RUN, 6'd0, 6'd0);
    write_count(7'd0);
    send(dfsft_pkg::CMD_ADD, 6'd0, 6'd0);
    send(dfsft_pkg::CMD_RUN, 6'd0, 6'd0);
    write_count(7'd127);
    send(dfsft_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send(dfsft_pkg::CMD_RUN, 6'd0, 6'd0);
    // Back-to-back edges with no idle gap between transactions.
    send(dfsft_pkg::CMD_CLEAR, 6'd0, 6'd0);
    for (int i = 0; i < 8; i++) begin
      s_tvalid <= 1;
      s_tdata  <= {2'b00, 6'($urandom), 6'($urandom), dfsft_pkg::CMD_ADD};
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 0;
    send(dfsft_pkg::CMD_RUN, 6'd0, 6'd0);
    // Random phases over several counts; one long receiver hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      n = (ph == 0) ? 1 : (ph == 1) ? 64 : $urandom_range(2, 20);
      write_count(7'(n));
      send(dfsft_pkg::CMD_CLEAR, 6'd0, 6'd0);
      random_graph(n, 14);
      if (ph == 2) hold_req <= 1;
      send(dfsft_pkg::CMD_RUN, 6'($urandom), 6'($urandom));
      send(dfsft_pkg::CMD_RUN, 6'($urandom), 6'($urandom));
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
